### design/ilip_pkg.sv
// ilip_pkg: shared types, codes and sizes for the indexed list core
// used by ilip_cell and indexed_list_insert_pop_core; no dependencies
package ilip_pkg;

	// list size and stored word width
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 16;
	// position arithmetic: one bit above the position so length plus position never wraps
	localparam int ARW   = POS_W + 1;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic signed [ARW-1:0] arith_t;

	localparam cnt_t DEPTH_C = cnt_t'(DEPTH);

	// operation codes
	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_POP    = 2'd2;
	localparam logic [1:0] KIND_GET    = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// request item
	typedef struct packed {
		logic [1:0]              kind;
		logic signed [POS_W-1:0] position;
		logic [31:0]             value_in;
	} req_t;

	// response item
	typedef struct packed {
		logic [31:0] value_out;
		logic [1:0]  status;
		logic [4:0]  length;
	} rsp_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic  ins;
		logic  pop;
		idx_t  at;
		data_t word;
	} cell_ctl_t;

endpackage

### design/ilip_cell.sv
// ilip_cell: one list entry of the cell chain
// compares its own index with the broadcast position and shifts with its neighbours
// depends on ilip_pkg
module ilip_cell (
	input  logic                  clk,
	input  ilip_pkg::cell_ctl_t   ctl,
	input  ilip_pkg::idx_t        idx,
	input  ilip_pkg::data_t       prev_word,
	input  ilip_pkg::data_t       next_word,
	output ilip_pkg::data_t       word
);

	ilip_pkg::data_t word_q;

	// insert: load at the position, take from the lower neighbour above it
	// pop: take from the upper neighbour at and above the position
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx == ctl.at) begin
				word_q <= ctl.word;
			end else if (idx > ctl.at) begin
				word_q <= prev_word;
			end
		end else if (ctl.pop) begin
			if (idx >= ctl.at) begin
				word_q <= next_word;
			end
		end
	end

	assign word = word_q;

endmodule

### design/indexed_list_insert_pop_core.sv
// indexed_list_insert_pop_core: bounded ordered list with append, insert, pop and get
// built as a chain of ilip_cell entries; depends on ilip_pkg and ilip_cell
//
//  channel | signals                     | direction | content
//  req     | req_valid, req_ready, req   | in        | kind, position, value_in
//  rsp     | rsp_valid, rsp_ready, rsp   | out       | value_out, status, length
//
// one item per cycle unless stalled: the operation resolves and every cell shifts in
// the transfer cycle, as each cell compares its own index with the position in parallel
// the response is registered and appears the cycle after the request transfer
// reset empties the list and the response register; entries need no clearing pass
// a stalled response holds req_ready low until it is taken (one output register)
module indexed_list_insert_pop_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ilip_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output ilip_pkg::rsp_t rsp
);

	ilip_pkg::cnt_t      count_q;
	logic                rsp_valid_q;
	ilip_pkg::rsp_t      rsp_q;
	logic                accept;
	ilip_pkg::arith_t    len_s;
	ilip_pkg::arith_t    pos_s;
	ilip_pkg::arith_t    sum_s;
	ilip_pkg::arith_t    ins_p;
	ilip_pkg::arith_t    pop_p;
	logic                full;
	logic                empty;
	logic                pop_range;
	logic                get_range;
	ilip_pkg::idx_t      rd_idx;
	ilip_pkg::data_t     rd_word;
	ilip_pkg::cell_ctl_t ctl;
	ilip_pkg::rsp_t      rsp_nxt;
	ilip_pkg::cnt_t      count_nxt;
	ilip_pkg::data_t     cell_word [ilip_pkg::DEPTH];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	// signed position arithmetic
	assign len_s = ilip_pkg::arith_t'(count_q);
	assign pos_s = ilip_pkg::arith_t'(req.position);
	assign sum_s = len_s + pos_s;
	assign full  = (count_q == ilip_pkg::DEPTH_C);
	assign empty = (count_q == '0);

	// insert position, clamped to the head and to the tail
	always_comb begin
		if (req.kind == ilip_pkg::KIND_APPEND) begin
			ins_p = len_s;
		end else if (pos_s < 0) begin
			ins_p = (sum_s < 0) ? '0 : sum_s;
		end else begin
			ins_p = (pos_s > len_s) ? len_s : pos_s;
		end
	end

	// pop and get range checks
	assign pop_p     = (pos_s < 0) ? sum_s : pos_s;
	assign pop_range = (pop_p < 0) || (pop_p >= len_s);
	assign get_range = (pos_s < 0) || (pos_s >= len_s);

	// read port over the cells
	assign rd_idx  = (req.kind == ilip_pkg::KIND_GET) ? pos_s[ilip_pkg::IDX_W-1:0]
	                                                  : pop_p[ilip_pkg::IDX_W-1:0];
	assign rd_word = cell_word[rd_idx];

	// operation decode
	always_comb begin
		ctl                 = '0;
		ctl.at              = ins_p[ilip_pkg::IDX_W-1:0];
		ctl.word            = ilip_pkg::data_t'(req.value_in);
		count_nxt           = count_q;
		rsp_nxt.value_out   = '0;
		rsp_nxt.status      = ilip_pkg::ST_OK;
		unique case (req.kind)
			ilip_pkg::KIND_APPEND, ilip_pkg::KIND_INSERT: begin
				if (full) begin
					rsp_nxt.status = ilip_pkg::ST_FULL;
				end else begin
					ctl.ins   = accept;
					count_nxt = count_q + 1'b1;
				end
			end
			ilip_pkg::KIND_POP: begin
				if (empty) begin
					rsp_nxt.status = ilip_pkg::ST_EMPTY;
				end else if (pop_range) begin
					rsp_nxt.status = ilip_pkg::ST_RANGE;
				end else begin
					ctl.pop           = accept;
					ctl.at            = pop_p[ilip_pkg::IDX_W-1:0];
					count_nxt         = count_q - 1'b1;
					rsp_nxt.value_out = 32'(rd_word);
				end
			end
			ilip_pkg::KIND_GET: begin
				if (empty) begin
					rsp_nxt.status = ilip_pkg::ST_EMPTY;
				end else if (get_range) begin
					rsp_nxt.status = ilip_pkg::ST_RANGE;
				end else begin
					rsp_nxt.value_out = 32'(rd_word);
				end
			end
			default: begin
				rsp_nxt.status = ilip_pkg::ST_OK;
			end
		endcase
		rsp_nxt.length = 5'(count_nxt);
	end

	// chain of cells
	for (genvar g = 0; g < ilip_pkg::DEPTH; g++) begin : g_cell
		ilip_pkg::data_t prev_w;
		ilip_pkg::data_t next_w;
		if (g == 0) begin : g_head
			assign prev_w = '0;
		end else begin : g_body
			assign prev_w = cell_word[g-1];
		end
		if (g == ilip_pkg::DEPTH - 1) begin : g_tail
			assign next_w = '0;
		end else begin : g_inner
			assign next_w = cell_word[g+1];
		end
		ilip_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (ilip_pkg::idx_t'(g)),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (cell_word[g])
		);
	end

	// length and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ilip_pkg::DEPTH_C)
		else $error("list length above depth");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the list");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not shrink the list");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q && rsp_q.length == 5'(count_q))
		else $error("response missing or length mismatch after transfer");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.status != ilip_pkg::ST_OK |-> rsp_q.value_out == '0)
		else $error("non-zero data with error status");
`endif

endmodule

### tb/ilip_list_checker.sv
// ilip_list_checker: watches both channels of the indexed list core, predicts each response
// and compares it with the one returned; depends on ilip_pkg
module ilip_list_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  ilip_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  ilip_pkg::rsp_t rsp,
	output int             err_count,
	output int             outstanding,
	output int             n_ok,
	output int             n_empty,
	output int             n_range,
	output int             n_full
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the list
	ilip_pkg::data_t store [ilip_pkg::DEPTH];
	int              fill;

	// predicted responses in transfer order
	ilip_pkg::rsp_t  pending_replies [$];
	ilip_pkg::rsp_t  want;

	initial begin
		err_count   = 0;
		outstanding = 0;
		n_ok        = 0;
		n_empty     = 0;
		n_range     = 0;
		n_full      = 0;
		fill        = 0;
	end

	// applies one operation to the shadow list and returns its response
	function automatic ilip_pkg::rsp_t list_op_outcome(input ilip_pkg::req_t op);
		ilip_pkg::rsp_t r;
		int             p;
		int             i;
		r.value_out = '0;
		r.status    = ilip_pkg::ST_OK;
		p = int'($signed(op.position));
		case (op.kind)
			ilip_pkg::KIND_APPEND, ilip_pkg::KIND_INSERT: begin
				if (fill >= ilip_pkg::DEPTH) begin
					r.status = ilip_pkg::ST_FULL;
				end else begin
					if (op.kind == ilip_pkg::KIND_APPEND) begin
						p = fill;
					end else begin
						// negative counts from the tail, clamped at the head
						if (p < 0) begin
							p = fill + p;
							if (p < 0)
								p = 0;
						end
						if (p > fill)
							p = fill;
					end
					for (i = fill; i > p; i--)
						store[i] = store[i-1];
					store[p] = ilip_pkg::data_t'(op.value_in);
					fill++;
				end
			end
			ilip_pkg::KIND_POP: begin
				if (fill == 0) begin
					r.status = ilip_pkg::ST_EMPTY;
				end else begin
					if (p < 0)
						p = fill + p;
					if (p < 0 || p >= fill) begin
						r.status = ilip_pkg::ST_RANGE;
					end else begin
						r.value_out = 32'(store[p]);
						for (i = p; i + 1 < fill; i++)
							store[i] = store[i+1];
						fill--;
					end
				end
			end
			default: begin
				// get never counts from the tail
				if (fill == 0)
					r.status = ilip_pkg::ST_EMPTY;
				else if (p < 0 || p >= fill)
					r.status = ilip_pkg::ST_RANGE;
				else
					r.value_out = 32'(store[p]);
			end
		endcase
		r.length = 5'(fill);
		return r;
	endfunction

	task automatic compare_field(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			err_count++;
			$display("%0d ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
		end
	endtask

	// response transfers are matched first: a response never belongs to a request
	// transferred at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			pending_replies.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_replies.size() == 0) begin
					err_count++;
					$display("%0d ns: unexpected response, expected none, got %h", $time, rsp);
				end else begin
					want = pending_replies.pop_front();
					compare_field("value_out", want.value_out, rsp.value_out);
					compare_field("status", 32'(want.status), 32'(rsp.status));
					compare_field("length", 32'(want.length), 32'(rsp.length));
					case (want.status)
						ilip_pkg::ST_OK:    n_ok++;
						ilip_pkg::ST_EMPTY: n_empty++;
						ilip_pkg::ST_RANGE: n_range++;
						default:            n_full++;
					endcase
				end
			end
			if (req_valid && req_ready)
				pending_replies.push_back(list_op_outcome(req));
		end
		outstanding = pending_replies.size();
	end

endmodule

### tb/indexed_list_insert_pop_core_tb.sv
// indexed_list_insert_pop_core_tb: stimulus, idling and verdict for the indexed list core
// depends on ilip_pkg, indexed_list_insert_pop_core and ilip_list_checker
module indexed_list_insert_pop_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_ITEMS  = 1500;
	localparam int HOLD_CYCLES = 60;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           rsp_ready = 1'b0;
	ilip_pkg::req_t req       = '0;
	logic           req_ready;
	logic           rsp_valid;
	ilip_pkg::rsp_t rsp;

	int err_count, outstanding, n_ok, n_empty, n_range, n_full;
	int stall_pct = 0;
	int idle_pct  = 0;
	int kinds_sent [4];
	bit hold_req  = 1'b0;
	bit hold_rx   = 1'b0;

	always #5 clk = ~clk;

	indexed_list_insert_pop_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	ilip_list_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.err_count   (err_count),
		.outstanding (outstanding),
		.n_ok        (n_ok),
		.n_empty     (n_empty),
		.n_range     (n_range),
		.n_full      (n_full)
	);

	// receiver: random stalls, plus one long hold-off
	always @(posedge clk) begin
		rsp_ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
	end

	// long hold-off so the core fills up and stalls its input
	initial begin
		wait (hold_req);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic ilip_pkg::req_t list_req(input logic [1:0] kind, input int pos,
			input logic [31:0] word);
		ilip_pkg::req_t r;
		r.kind     = kind;
		r.position = 16'(pos);
		r.value_in = word;
		return r;
	endfunction

	// random operation, biased towards growing or shrinking the list
	function automatic ilip_pkg::req_t random_op(input bit growing);
		int          roll;
		int          pos;
		logic [1:0]  kind;
		roll = $urandom_range(99);
		if (growing)
			kind = (roll < 35) ? ilip_pkg::KIND_APPEND :
				(roll < 65) ? ilip_pkg::KIND_INSERT :
				(roll < 85) ? ilip_pkg::KIND_POP : ilip_pkg::KIND_GET;
		else
			kind = (roll < 10) ? ilip_pkg::KIND_APPEND :
				(roll < 25) ? ilip_pkg::KIND_INSERT :
				(roll < 70) ? ilip_pkg::KIND_POP : ilip_pkg::KIND_GET;
		// mostly positions near the list, sometimes anywhere in the field
		if ($urandom_range(99) < 70)
			pos = int'($urandom_range(40)) - 20;
		else
			pos = int'($urandom_range(16'hFFFF));
		return list_req(kind, pos, $urandom);
	endfunction

	// offers one request and returns at the edge of its transfer
	task automatic offer(input ilip_pkg::req_t item);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		kinds_sent[item.kind]++;
		do @(negedge clk); while (!req_ready);
		@(posedge clk);
	endtask

	task automatic random_burst(input int n);
		int k;
		for (k = 0; k < n; k++)
			offer(random_op(((k / 24) % 2) == 0));
	endtask

	initial begin
		int i;
		foreach (kinds_sent[i])
			kinds_sent[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty list
		offer(list_req(ilip_pkg::KIND_POP, 0, 32'h0));
		offer(list_req(ilip_pkg::KIND_GET, 0, 32'h0));
		// data extremes at the tail
		offer(list_req(ilip_pkg::KIND_APPEND, 0, 32'h0000_0000));
		offer(list_req(ilip_pkg::KIND_APPEND, -1, 32'hFFFF_FFFF));
		// insert positions: clamp at head, past the length, middle, from the tail
		offer(list_req(ilip_pkg::KIND_INSERT, -32768, 32'hA5A5_A5A5));
		offer(list_req(ilip_pkg::KIND_INSERT, 32767, 32'h5A5A_5A5A));
		offer(list_req(ilip_pkg::KIND_INSERT, 1, 32'h1234_5678));
		offer(list_req(ilip_pkg::KIND_INSERT, -1, 32'h8765_4321));
		// fill to the limit, then try to add more
		for (i = 0; i < ilip_pkg::DEPTH - 6; i++)
			offer(list_req(ilip_pkg::KIND_APPEND, 0, $urandom));
		offer(list_req(ilip_pkg::KIND_INSERT, 0, 32'hDEAD_BEEF));
		offer(list_req(ilip_pkg::KIND_APPEND, 0, 32'hDEAD_BEEF));
		// get out of range on both sides, and the last entry
		offer(list_req(ilip_pkg::KIND_GET, -1, 32'h0));
		offer(list_req(ilip_pkg::KIND_GET, 32767, 32'h0));
		offer(list_req(ilip_pkg::KIND_GET, ilip_pkg::DEPTH - 1, 32'h0));
		// pop out of range on both sides, then tail and head
		offer(list_req(ilip_pkg::KIND_POP, -32768, 32'h0));
		offer(list_req(ilip_pkg::KIND_POP, 32767, 32'h0));
		offer(list_req(ilip_pkg::KIND_POP, -1, 32'h0));
		offer(list_req(ilip_pkg::KIND_POP, 0, 32'h0));

		// back-pressure: receiver holds off while requests keep coming
		hold_req <= 1'b1;
		random_burst(24);

		// no idling
		random_burst(RAND_ITEMS / 4 - 24);
		// sender mostly idle
		idle_pct = 85;
		random_burst(RAND_ITEMS / 4);
		// receiver mostly stalling
		idle_pct = 0;
		stall_pct <= 85;
		random_burst(RAND_ITEMS / 4);
		// both sides idling now and then
		idle_pct = 16;
		stall_pct <= 16;
		random_burst(RAND_ITEMS / 4);

		req_valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (4) @(posedge clk);

		$display("ran %0d requests: %0d append, %0d insert, %0d pop, %0d get",
			kinds_sent.sum(),
			kinds_sent[ilip_pkg::KIND_APPEND], kinds_sent[ilip_pkg::KIND_INSERT],
			kinds_sent[ilip_pkg::KIND_POP], kinds_sent[ilip_pkg::KIND_GET]);
		$display("responses checked: %0d ok, %0d empty list, %0d out of range, %0d full list",
			n_ok, n_empty, n_range, n_full);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
